/* rtl/core/homogeneous_point_transform_top_macros.svh */
// assertion macros for the homogeneous point transform
// used by homogeneous_point_transform_top; needs aclk and aresetn in scope
`ifndef HOMOGENEOUS_POINT_TRANSFORM_TOP_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HPT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("assertion failed");
`define HPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPT_ASSERT_NEVER(label, cond)
`define HPT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/hpt_pkg.sv */
// types and constants of the homogeneous point transform
// no dependencies
package hpt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ENTRY_W     = 32;
    localparam int CFG_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [COORD_WIDTH-1:0] z_in;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          w_zero;
        logic                          saturated;
    } out_item_t;

endpackage

/* rtl/core/homogeneous_point_transform_top.sv */
// homogeneous 4x4 point transform with perspective divide, fully pipelined
// depends on hpt_pkg and homogeneous_point_transform_top_macros.svh
//
// usage
// - s_valid/s_ready/s_data take one point (x_in, y_in, z_in) per item, signed fixed point
// - m_valid/m_ready/m_data give one transformed point per item, with w_zero and saturated
// - cfg_valid/cfg_ready/cfg_index/cfg_data write the matrix, two entries per register;
//   cfg_ready is always high, an index of eight or more is ignored; write only when idle
// - the path from input acceptance to output valid runs through COORD_WIDTH + 5
//   register stages: one product stage, one row sum stage, one magnitude stage,
//   one setup stage, one stage per quotient bit, one output stage
// - throughput is one item per cycle while the receiver does not stall; the restoring
//   divider has one stage per bit
// - every stage has its own valid bit and moves on when the stage after it is free,
//   so bubbles close up while the receiver stalls and s_ready stays high until
//   the whole pipeline is full
// - reset clears every valid bit and loads the reset matrix CFG_RESET
module homogeneous_point_transform_top
    import hpt_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = ENTRY_W + CW;     // one product
    localparam int SW  = PW + 2;           // sum of four products
    localparam int WW  = SW + CW + FRAC;   // divider working width
    localparam int DV  = 3;                // first divider stage
    localparam int OS  = DV + CW + 1;      // output stage
    localparam int NST = OS + 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] cfg_reg [CFG_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(CFG_REGS)) begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // stage valid bits and advance chain
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST:0]   adv;

    always_comb begin
        adv[NST] = m_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NST; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];

    // stage 0: sixteen products, column three is a shift by the unit w
    logic signed [PW-1:0] prod_reg [4][4];
    logic signed [PW-1:0] prod_next [4][4];
    logic signed [CW-1:0] pt [3];

    always_comb begin
        logic signed [ENTRY_W-1:0] ent;
        pt[0] = s_data.x_in;
        pt[1] = s_data.y_in;
        pt[2] = s_data.z_in;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                ent = cfg_reg[r*2 + c/2][(c%2)*ENTRY_W +: ENTRY_W];
                prod_next[r][c] = ent * pt[c];
            end
            ent = cfg_reg[r*2 + 1][ENTRY_W +: ENTRY_W];
            prod_next[r][3] = PW'(ent) <<< FRAC;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= prod_next;
        end
    end

    // stage 1: row sums
    logic signed [SW-1:0] sum_reg [4];
    logic signed [SW-1:0] sum_next [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                        + SW'(prod_reg[r][2]) + SW'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sum_reg <= sum_next;
        end
    end

    // stage 2: signs and magnitudes, w zero test
    logic [SW-1:0] mag_reg [4];
    logic [SW-1:0] mag_next [4];
    logic [3:0]    sgn_reg, sgn_next;
    logic          wz2_reg, wz2_next;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sgn_next[r] = sum_reg[r][SW-1];
            mag_next[r] = sgn_next[r] ? SW'(-sum_reg[r]) : SW'(sum_reg[r]);
        end
        wz2_next = (sum_reg[3] == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            mag_reg <= mag_next;
            sgn_reg <= sgn_next;
            wz2_reg <= wz2_next;
        end
    end

    // divider: entry 0 is setup, entry k+1 holds the result after quotient bit k
    logic [WW-1:0] rem_reg [CW+1][3];
    logic [WW-1:0] rem_next [CW+1][3];
    logic [CW-1:0] quo_reg [CW+1][3];
    logic [CW-1:0] quo_next [CW+1][3];
    logic [SW-1:0] den_reg [CW+1];
    logic [SW-1:0] den_next [CW+1];
    logic [2:0]    neg_reg [CW+1];
    logic [2:0]    neg_next [CW+1];
    logic [2:0]    ovf_reg [CW+1];
    logic [2:0]    ovf_next [CW+1];
    logic [CW:0]   wzd_reg, wzd_next;

    always_comb begin
        logic [WW-1:0] trial;
        // setup: a quotient of more than CW bits is flagged before the bit steps
        den_next[0] = mag_reg[3];
        wzd_next[0] = wz2_reg;
        for (int l = 0; l < 3; l++) begin
            rem_next[0][l] = WW'(mag_reg[l]) << FRAC;
            quo_next[0][l] = '0;
            neg_next[0][l] = sgn_reg[l] ^ sgn_reg[3];
            ovf_next[0][l] = rem_next[0][l] >= (WW'(mag_reg[3]) << CW);
        end
        for (int k = 0; k < CW; k++) begin
            den_next[k+1] = den_reg[k];
            wzd_next[k+1] = wzd_reg[k];
            neg_next[k+1] = neg_reg[k];
            ovf_next[k+1] = ovf_reg[k];
            for (int l = 0; l < 3; l++) begin
                trial = WW'(den_reg[k]) << (CW - 1 - k);
                rem_next[k+1][l] = rem_reg[k][l];
                quo_next[k+1][l] = quo_reg[k][l];
                if (rem_reg[k][l] >= trial) begin
                    rem_next[k+1][l]           = rem_reg[k][l] - trial;
                    quo_next[k+1][l][CW-1-k]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= CW; k++) begin
            if (adv[DV+k]) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
                neg_reg[k] <= neg_next[k];
                ovf_reg[k] <= ovf_next[k];
                wzd_reg[k] <= wzd_next[k];
            end
        end
    end

    // output stage: sign, saturation and the w zero case
    out_item_t out_reg, out_next;

    always_comb begin
        logic signed [CW-1:0] res [3];
        logic [CW-1:0]        q;
        logic                 sat;
        logic [2:0]           lane_sat;
        for (int l = 0; l < 3; l++) begin
            q = quo_reg[CW][l];
            if (neg_reg[CW][l]) begin
                sat = ovf_reg[CW][l] || (q > {1'b1, {(CW-1){1'b0}}});
                res[l] = sat ? {1'b1, {(CW-1){1'b0}}} : -q;
            end else begin
                sat = ovf_reg[CW][l] || q[CW-1];
                res[l] = sat ? {1'b0, {(CW-1){1'b1}}} : q;
            end
            lane_sat[l] = sat;
        end
        if (wzd_reg[CW]) begin
            out_next.x_out     = '0;
            out_next.y_out     = '0;
            out_next.z_out     = '0;
            out_next.w_zero    = 1'b1;
            out_next.saturated = 1'b0;
        end else begin
            out_next.x_out     = res[0];
            out_next.y_out     = res[1];
            out_next.z_out     = res[2];
            out_next.w_zero    = 1'b0;
            out_next.saturated = |lane_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[OS]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[OS];
    assign m_data  = out_reg;

    // checks
    logic out_coord_nz;

    assign out_coord_nz = |{m_data.x_out, m_data.y_out, m_data.z_out};

    `include "homogeneous_point_transform_top_macros.svh"

    `HPT_ASSERT_NEVER(a_wz_sat, m_valid && m_data.w_zero && m_data.saturated)
    `HPT_ASSERT_NEVER(a_wz_zero, m_valid && m_data.w_zero && out_coord_nz)
    `HPT_ASSERT_NEXT(a_in_capture, s_valid && s_ready, vld_reg[0])

endmodule

/* bench/homogeneous_point_transform_top_tb.sv */
// testbench for the homogeneous 4x4 point transform with perspective divide
// depends on hpt_pkg and homogeneous_point_transform_top; self-checking, no files read
module homogeneous_point_transform_top_tb;
    import hpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // pipeline depth is COORD_WIDTH + 5; leave some margin
    localparam int DRAIN_CYCLES = COORD_WIDTH + 20;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW0_01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW3_01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW3_23 = 4'd7;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED  = 4'd8;
    localparam logic [CFG_IDX_W-1:0] IDX_LAST    = 4'd15;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor's own copy of the matrix registers
    logic [CFG_DATA_W-1:0] matrix_regs [CFG_REGS];
    out_item_t             pending_points [$];
    int                    error_count = 0;
    int                    points_sent = 0;
    int                    points_checked = 0;
    int                    wzero_seen = 0;
    int                    sat_seen = 0;
    // receiver stall pattern mode: 0 never stall, 1 light, 2 heavy
    int                    stall_mode = 0;

    homogeneous_point_transform_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // signed entry of the matrix, row r column c
    function automatic logic signed [ENTRY_W-1:0] matrix_entry_of(int r, int c);
        logic [CFG_DATA_W-1:0] reg_word;
        reg_word = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? reg_word[63:32] : reg_word[31:0];
    endfunction

    // one projected coordinate: (sum << FRAC) / wsum, truncated, clipped to range
    function automatic logic signed [COORD_WIDTH-1:0] project_coord(
        logic signed [127:0] row_sum, logic signed [127:0] w_sum, ref logic clipped);
        logic signed [127:0] quotient;
        logic signed [127:0] max_pos;
        logic signed [127:0] max_neg;
        max_pos = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
        max_neg = -(128'sd1 <<< (COORD_WIDTH - 1));
        quotient = (row_sum <<< FRAC_BITS) / w_sum;
        if (quotient > max_pos) begin
            clipped = 1'b1;
            return max_pos[COORD_WIDTH-1:0];
        end
        if (quotient < max_neg) begin
            clipped = 1'b1;
            return max_neg[COORD_WIDTH-1:0];
        end
        return quotient[COORD_WIDTH-1:0];
    endfunction

    function automatic out_item_t transform_point(in_item_t pt);
        logic signed [127:0] row_sums [4];
        logic signed [127:0] coords [4];
        out_item_t           res;
        logic                clipped;
        coords[0] = pt.x_in;
        coords[1] = pt.y_in;
        coords[2] = pt.z_in;
        coords[3] = 128'sd1 <<< FRAC_BITS;
        for (int r = 0; r < 4; r++) begin
            row_sums[r] = 0;
            for (int c = 0; c < 4; c++) begin
                row_sums[r] += 128'(matrix_entry_of(r, c)) * coords[c];
            end
        end
        res = '0;
        if (row_sums[3] == 0) begin
            res.w_zero = 1'b1;
            return res;
        end
        clipped = 1'b0;
        res.x_out = project_coord(row_sums[0], row_sums[3], clipped);
        res.y_out = project_coord(row_sums[1], row_sums[3], clipped);
        res.z_out = project_coord(row_sums[2], row_sums[3], clipped);
        res.saturated = clipped;
        return res;
    endfunction

    // send one point; sender may pause for a random gap first
    // valid stays high after acceptance so that items can follow back to back
    task automatic send_point(in_item_t pt, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pt;
        pending_points.push_back(transform_point(pt));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
    endtask

    // burst of random points; bursts keep valid high back to back
    task automatic send_burst(int count, int coord_kind);
        in_item_t pt;
        int       burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            pt = random_point(coord_kind);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                send_point(pt, $urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
            end else begin
                send_point(pt, 0);
            end
            burst_left--;
        end
    endtask

    // kind 0: full range, 1: small coordinates, 2: extremes
    function automatic in_item_t random_point(int coord_kind);
        in_item_t pt;
        logic [COORD_WIDTH-1:0] vals [3];
        for (int k = 0; k < 3; k++) begin
            case (coord_kind)
                1: vals[k] = COORD_WIDTH'($signed($urandom_range(0, 32'h0008_0000)) -
                                          32'sh0004_0000);
                2: vals[k] = ($urandom_range(0, 1)) ? {1'b0, {(COORD_WIDTH-1){1'b1}}}
                                                    : {1'b1, {(COORD_WIDTH-1){1'b0}}};
                default: vals[k] = $urandom;
            endcase
        end
        pt.x_in = vals[0];
        pt.y_in = vals[1];
        pt.z_in = vals[2];
        return pt;
    endfunction

    // stop sending, wait until every expected point has arrived, then let it settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_points.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // out-of-range indexes are dropped by the block
        if (idx < CFG_REGS) matrix_regs[idx[2:0]] = value;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pack_entries(int lo, int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    // random matrix, full-width entries when wide_entries is set; small entries keep most quotients in range
    task automatic load_random_matrix(bit wide_entries);
        for (int i = 0; i < CFG_REGS; i++) begin
            if (wide_entries)
                write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
            else
                write_reg(CFG_IDX_W'(i), pack_entries(
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
        end
    endtask

    task automatic load_identity();
        for (int i = 0; i < CFG_REGS; i++) write_reg(CFG_IDX_W'(i), CFG_RESET[i]);
    endtask

    // directed: reset matrix CFG_RESET, extremes of each coordinate
    task automatic test_identity_extremes();
        in_item_t pt;
        logic [COORD_WIDTH-1:0] corner [4];
        corner[0] = '0;
        corner[1] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        corner[2] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        corner[3] = '1;
        for (int k = 0; k < 4; k++) begin
            pt.x_in = corner[k];
            pt.y_in = corner[(k + 1) % 4];
            pt.z_in = corner[(k + 2) % 4];
            send_point(pt, 0);
        end
        pt.x_in = 32'h0001_8000;
        pt.y_in = 32'hfffe_8000;
        pt.z_in = 32'h5555_aaaa;
        send_point(pt, 0);
        wait_drained();
    endtask

    // directed: w row zeroed gives the w-zero flag
    task automatic test_w_zero();
        in_item_t pt;
        write_reg(IDX_ROW3_01, '0);
        write_reg(IDX_ROW3_23, '0);
        for (int i = 0; i < 4; i++) begin
            pt = random_point(0);
            send_point(pt, 0);
        end
        wait_drained();
        // w = z: zero only when z is zero
        write_reg(IDX_ROW3_23, pack_entries(32'h0001_0000, 0));
        pt.x_in = 32'h0001_0000;
        pt.y_in = 32'h0002_0000;
        pt.z_in = '0;
        send_point(pt, 0);
        pt.z_in = 32'h0000_0001;
        send_point(pt, 0);
        pt.z_in = 32'hffff_ffff;
        send_point(pt, 0);
        wait_drained();
    endtask

    // directed: huge scale and tiny w force clipping both ways, plus truncation, negative w and ignored writes
    task automatic test_saturation_rounding();
        in_item_t pt;
        load_identity();
        write_reg(IDX_ROW3_23, pack_entries(0, 1));
        pt.x_in = 32'h0000_0001;
        pt.y_in = 32'hffff_ffff;
        pt.z_in = 32'h8000_0000;
        send_point(pt, 0);
        wait_drained();
        // w = 3.0: quotient not exact, truncation toward zero
        write_reg(IDX_ROW3_23, pack_entries(0, 32'h0003_0000));
        pt.x_in = 32'h0000_0001;
        pt.y_in = 32'hffff_fffe;
        pt.z_in = 32'h0007_0000;
        send_point(pt, 0);
        wait_drained();
        // negative w flips signs
        write_reg(IDX_ROW3_23, pack_entries(0, 32'hffff_0000));
        pt.x_in = 32'h8000_0000;
        pt.y_in = 32'h7fff_ffff;
        pt.z_in = 32'h0000_0000;
        send_point(pt, 0);
        wait_drained();
        // ignored writes beyond the register list
        write_reg(IDX_UNUSED, '1);
        write_reg(IDX_LAST, '1);
        write_reg(IDX_ROW0_01, {32'h8000_0000, 32'h7fff_ffff});
        pt = random_point(2);
        send_point(pt, 0);
        wait_drained();
    endtask

    // random: several matrices, the last phase with extreme register values
    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            stall_mode = phase % 3;
            if (phase == 5) begin
                for (int i = 0; i < CFG_REGS; i++)
                    write_reg(CFG_IDX_W'(i), (i % 2) ? '1 : {1'b1, {(CFG_DATA_W-1){1'b0}}});
            end else begin
                load_random_matrix(phase == 4);
            end
            send_burst(80, (phase == 3) ? 0 : 1);
            send_burst(15, 0);
            send_burst(5, 2);
            wait_drained();
        end
    endtask

    // receiver stall pattern, driven at the rising edge
    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result checker: compare every accepted point with the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result x=%h y=%h z=%h",
                       m_data.x_out, m_data.y_out, m_data.z_out);
                error_count++;
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (want.w_zero) wzero_seen++;
                if (want.saturated) sat_seen++;
                if (m_data.x_out !== want.x_out) begin
                    $error("x_out expected %h actual %h", want.x_out, m_data.x_out);
                    error_count++;
                end
                if (m_data.y_out !== want.y_out) begin
                    $error("y_out expected %h actual %h", want.y_out, m_data.y_out);
                    error_count++;
                end
                if (m_data.z_out !== want.z_out) begin
                    $error("z_out expected %h actual %h", want.z_out, m_data.z_out);
                    error_count++;
                end
                if (m_data.w_zero !== want.w_zero) begin
                    $error("w_zero expected %b actual %b", want.w_zero, m_data.w_zero);
                    error_count++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated expected %b actual %b",
                           want.saturated, m_data.saturated);
                    error_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < CFG_REGS; i++) matrix_regs[i] = CFG_RESET[i];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity_extremes();
        test_w_zero();
        test_saturation_rounding();
        test_random_stream();
        if (pending_points.size() != 0) begin
            $error("%0d expected results never arrived", pending_points.size());
            error_count++;
        end
        $display("points sent %0d, checked %0d, w zero %0d, clipped %0d",
                 points_sent, points_checked, wzero_seen, sat_seen);
        $display("covered identity, random and extreme matrices with varied stalls");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
